// ===== sv/vgrt_pkg.sv =====
`default_nettype none
package vgrt_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DeltaBits = 32;
  localparam int unsigned SideBits  = 40;
  localparam int unsigned StepBits  = 10;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned AccBits   = 66;

  localparam logic [1:0] StatQuery = 2'd0;
  localparam logic [1:0] StatHit   = 2'd1;
  localparam logic [1:0] StatMiss  = 2'd2;
  localparam logic [1:0] StatNoRay = 2'd3;

  localparam logic [2:0] FaceNone = 3'd6;
  localparam logic [1:0] AxisNone = 2'd3;

  localparam logic [1:0] SignZero  = 2'd0;
  localparam logic [1:0] SignPlus  = 2'd1;
  localparam logic [1:0] SignMinus = 2'd3;

  localparam logic RegMaxDistance = 1'b0;
  localparam logic RegMaxSteps    = 1'b1;

  typedef enum logic [1:0] {
    EMIT_START_E,
    EMIT_NORAY_E,
    EMIT_HIT_E,
    EMIT_STEP_E
  } emit_kind_e;

  typedef struct packed {
    logic                         operation;
    logic signed [31:0]           origin_x;
    logic signed [31:0]           origin_y;
    logic signed [31:0]           origin_z;
    logic signed [15:0]           dir_x;
    logic signed [15:0]           dir_y;
    logic signed [15:0]           dir_z;
    logic                         occupied;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]           voxel_x;
    logic signed [15:0]           voxel_y;
    logic signed [15:0]           voxel_z;
    logic [1:0]                   status;
    logic [2:0]                   face;
    logic [StepBits-1:0]          steps_taken;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       div_first;
    logic       setup_wr;
    logic [1:0] axis;
    logic       step;
    logic       abs_en;
    logic       sq_en;
    logic       acc_en;
    logic       emit;
    emit_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic ray_active;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/vgrt_ctrl.sv =====
`default_nettype none
module vgrt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 op_i,
  input  wire logic                 occ_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire vgrt_pkg::dp_status_t status_i,
  output vgrt_pkg::dp_cmd_t         cmd_o
);
  import vgrt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StStep  = 3'd4;
  localparam logic [2:0] StSq    = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  axis_q, axis_d;
  emit_kind_e  kind_q, kind_d;
  logic        out_valid_q, out_valid_d;
  logic        accept, out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Sequence one transaction through setup, step and emit phases
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.kind  = kind_q;
    cmd_o.axis  = axis_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (!op_i) begin
            cmd_o.load = 1'b1;
            axis_d     = 2'd0;
            state_d    = StSetup;
          end else if (!status_i.ray_active) begin
            kind_d  = EMIT_NORAY_E;
            state_d = StEmit;
          end else if (occ_i) begin
            kind_d  = EMIT_HIT_E;
            state_d = StEmit;
          end else begin
            state_d = StStep;
          end
        end
      end
      StSetup: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) state_d = StMul;
      end
      StMul: begin
        cmd_o.setup_wr = 1'b1;
        if (axis_q == 2'd2) begin
          kind_d  = EMIT_START_E;
          state_d = StEmit;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = StSetup;
        end
      end
      StStep: begin
        cmd_o.step = 1'b1;
        cnt_d      = '0;
        state_d    = StSq;
      end
      StSq: begin
        // Three-stage pipe: difference, square, accumulate
        cmd_o.axis   = cnt_q[1:0];
        cmd_o.abs_en = (cnt_q < 5'd3);
        cmd_o.sq_en  = (cnt_q >= 5'd1) && (cnt_q <= 5'd3);
        cmd_o.acc_en = (cnt_q >= 5'd2);
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          kind_d  = EMIT_STEP_E;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      axis_q      <= '0;
      kind_q      <= EMIT_START_E;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/vgrt_datapath.sv =====
`default_nettype none
module vgrt_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vgrt_pkg::in_item_t  in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i,
  input  wire vgrt_pkg::dp_cmd_t   cmd_i,
  output vgrt_pkg::dp_status_t     status_o,
  output vgrt_pkg::out_item_t      out_data_o
);
  import vgrt_pkg::*;

  localparam logic [SideBits-1:0] SideMax = '1;

  logic [15:0]          max_dist_q;
  logic [StepBits-1:0]  max_steps_q;
  logic [31:0]          limit_sq_q;
  logic                 active_q;
  logic [CoordBits-1:0] voxel_q  [3];
  logic [31:0]          origin_q [3];
  logic [15:0]          dir_q    [3];
  logic [1:0]           sign_q   [3];
  logic [DeltaBits-1:0] delta_q  [3];
  logic [SideBits-1:0]  side_q   [3];
  logic [1:0]           last_q;
  logic [StepBits-1:0]  count_q;
  logic [16:0]          rem_q;
  logic [DivSteps-1:0]  quo_q;
  logic [31:0]          abs_q;
  logic [63:0]          prod_q;
  logic [AccBits-1:0]   acc_q;
  out_item_t            out_q;

  // Configuration registers and the squared limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= 16'd200;
      max_steps_q <= 10'd500;
    end else if (cfg_we_i) begin
      if (cfg_index_i == {7'd0, RegMaxDistance}) max_dist_q <= cfg_data_i;
      if (cfg_index_i == {7'd0, RegMaxSteps}) max_steps_q <= cfg_data_i[StepBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    limit_sq_q <= 32'(max_dist_q * max_dist_q);
  end

  // Setup arithmetic for the selected axis
  logic [15:0] dir_sel;
  logic        dir_neg;
  logic [15:0] mag;
  logic [17:0] div_t;
  logic        div_ge;
  logic [16:0] frac_f;
  logic [48:0] side_prod;

  always_comb begin
    dir_sel   = dir_q[cmd_i.axis];
    dir_neg   = dir_sel[15];
    mag       = dir_neg ? 16'(-dir_sel) : dir_sel;
    div_t     = {rem_q, cmd_i.div_first};
    div_ge    = (div_t >= {2'b00, mag});
    frac_f    = dir_neg ? {1'b0, origin_q[cmd_i.axis][FracBits-1:0]}
                        : 17'(17'h10000 - {1'b0, origin_q[cmd_i.axis][FracBits-1:0]});
    side_prod = 49'(frac_f * quo_q);
  end

  // Axis choice by smallest side distance, ties go to the later axis
  logic [1:0]          ax;
  logic [SideBits:0]   side_sum;
  always_comb begin
    if (side_q[0] < side_q[1] && side_q[0] < side_q[2]) ax = 2'd0;
    else if (side_q[1] < side_q[2]) ax = 2'd1;
    else ax = 2'd2;
    side_sum = {1'b0, side_q[ax]} + {9'd0, delta_q[ax]};
  end

  // Distance of the voxel corner from the origin on one axis
  logic signed [32:0] corner, diff;
  always_comb begin
    corner = {voxel_q[cmd_i.axis][CoordBits-1], voxel_q[cmd_i.axis], 16'd0};
    diff   = corner - {origin_q[cmd_i.axis][31], origin_q[cmd_i.axis]};
  end

  logic miss;
  assign miss = (acc_q > {2'b00, limit_sq_q, 32'd0}) || (count_q >= max_steps_q);

  logic [2:0] hit_face;
  always_comb begin
    hit_face = FaceNone;
    if (last_q != AxisNone) begin
      hit_face = {last_q, (sign_q[last_q] == SignPlus) ? 1'b0 : 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (cmd_i.load) begin
      active_q <= 1'b1;
    end else if (cmd_i.emit && (cmd_i.kind == EMIT_HIT_E ||
                                (cmd_i.kind == EMIT_STEP_E && miss))) begin
      active_q <= 1'b0;
    end
  end

  // Ray state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      origin_q[0] <= in_data_i.origin_x;
      origin_q[1] <= in_data_i.origin_y;
      origin_q[2] <= in_data_i.origin_z;
      dir_q[0]    <= in_data_i.dir_x;
      dir_q[1]    <= in_data_i.dir_y;
      dir_q[2]    <= in_data_i.dir_z;
      voxel_q[0]  <= in_data_i.origin_x[FracBits +: CoordBits];
      voxel_q[1]  <= in_data_i.origin_y[FracBits +: CoordBits];
      voxel_q[2]  <= in_data_i.origin_z[FracBits +: CoordBits];
      last_q      <= AxisNone;
      count_q     <= '0;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? 17'(div_t - {2'b00, mag}) : div_t[16:0];
      quo_q <= {quo_q[DivSteps-2:0], div_ge};
    end
    if (cmd_i.setup_wr) begin
      delta_q[cmd_i.axis] <= quo_q;
      if (mag == '0) begin
        sign_q[cmd_i.axis] <= SignZero;
        side_q[cmd_i.axis] <= SideMax;
      end else begin
        sign_q[cmd_i.axis] <= dir_neg ? SignMinus : SignPlus;
        side_q[cmd_i.axis] <= SideBits'(side_prod[48:FracBits]);
      end
    end
    if (cmd_i.step) begin
      side_q[ax] <= side_sum[SideBits] ? SideMax : side_sum[SideBits-1:0];
      if (sign_q[ax] == SignPlus) voxel_q[ax] <= voxel_q[ax] + 1'b1;
      else if (sign_q[ax] == SignMinus) voxel_q[ax] <= voxel_q[ax] - 1'b1;
      last_q  <= ax;
      count_q <= count_q + 1'b1;
      acc_q   <= '0;
    end
    if (cmd_i.abs_en) abs_q  <= diff[32] ? 32'(-diff) : diff[31:0];
    if (cmd_i.sq_en)  prod_q <= abs_q * abs_q;
    if (cmd_i.acc_en) acc_q  <= acc_q + {2'b00, prod_q};
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.voxel_x     <= voxel_q[0];
      out_q.voxel_y     <= voxel_q[1];
      out_q.voxel_z     <= voxel_q[2];
      out_q.steps_taken <= count_q;
      out_q.face        <= FaceNone;
      case (cmd_i.kind)
        EMIT_START_E: out_q.status <= StatQuery;
        EMIT_HIT_E: begin
          out_q.status <= StatHit;
          out_q.face   <= hit_face;
        end
        EMIT_STEP_E: out_q.status <= miss ? StatMiss : StatQuery;
        default: begin
          out_q.status      <= StatNoRay;
          out_q.voxel_x     <= '0;
          out_q.voxel_y     <= '0;
          out_q.voxel_z     <= '0;
          out_q.steps_taken <= '0;
        end
      endcase
    end
  end

  assign status_o.ray_active = active_q;
  assign out_data_o          = out_q;

endmodule
`default_nettype wire

// ===== sv/voxel_grid_ray_traversal_unit.sv =====
// Channel  | Direction | Handshake              | Payload
// in       | input     | in_valid_i / in_stall_o   | vgrt_pkg::in_item_t
// out      | output    | out_valid_o / out_stall_i | vgrt_pkg::out_item_t
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// A ray start runs three restoring divisions for the reciprocal distances on one
// shared divider, with a setup and a multiply state per axis and a final emit state.
// An answer that steps runs the shared 32x32 squarer pipe of the distance check first;
// a hit or no-ray answer goes straight to emit. One transaction is in work at a time.
// Reset clears the controller, ray activity and the config registers to their defaults.
// A stalled result holds in the output register; the input stalls until it can be written.
`default_nettype none
module voxel_grid_ray_traversal_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire vgrt_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output vgrt_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [7:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  import vgrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  vgrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (in_data_i.operation),
    .occ_i      (in_data_i.occupied),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vgrt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== sv/vgrt_checker.sv =====
`default_nettype none
module vgrt_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire vgrt_pkg::out_item_t out_data_o
);
  import vgrt_pkg::*;

  // Work on an accepted transaction blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A no-ray result carries no voxel, face or step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == StatNoRay) |->
    (out_data_o.face == FaceNone && out_data_o.steps_taken == '0))
    else $error("no-ray result carries ray data");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // Query and miss results never report a face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StatQuery || out_data_o.status == StatMiss)) |->
    out_data_o.face == FaceNone)
    else $error("face set on query or miss");

endmodule

bind voxel_grid_ray_traversal_unit vgrt_checker u_vgrt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import vgrt_pkg::*;

  localparam logic [7:0] CfgMaxDistance = 8'd0;
  localparam logic [7:0] CfgMaxSteps    = 8'd1;
  localparam logic [7:0] CfgUnused      = 8'd5;
  localparam logic       OpStart        = 1'b0;
  localparam logic       OpAnswer       = 1'b1;
  localparam logic [39:0] SideSat       = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] DeltaSat      = 32'hFFFF_FFFF;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;

  voxel_grid_ray_traversal_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predictor state
  logic [15:0] lim_dist;
  logic [9:0]  lim_steps;
  logic        trace_on;
  logic [15:0] cell_pos [3];
  logic [31:0] org [3];
  logic [1:0]  sgn [3];
  logic [31:0] dlt [3];
  logic [39:0] sdist [3];
  logic [1:0]  prev_axis;
  logic [9:0]  nsteps;

  in_item_t  pending_q [$];
  out_item_t expected_q [$];
  int errors;
  bit noidle_in, noidle_out, hold_out;
  bit in_fire;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Append a transaction to the send queue
  task automatic enqueue(input in_item_t it);
    pending_q.insert(pending_q.size(), it);
  endtask

  function automatic out_item_t make_result(logic [1:0] st, logic [2:0] fc, bit blank);
    out_item_t r;
    r.voxel_x = blank ? '0 : cell_pos[0];
    r.voxel_y = blank ? '0 : cell_pos[1];
    r.voxel_z = blank ? '0 : cell_pos[2];
    r.status = st;
    r.face = fc;
    r.steps_taken = blank ? '0 : nsteps;
    return r;
  endfunction

  function automatic bit past_range();
    logic [131:0] acc;
    logic signed [64:0] d;
    logic [63:0] m;
    acc = '0;
    for (int a = 0; a < 3; a++) begin
      d = ($signed({{33{cell_pos[a][15]}}, cell_pos[a], 16'd0}))
          - $signed({{33{org[a][31]}}, org[a]});
      m = d[64] ? 64'(-d) : 64'(d);
      acc += 132'(m) * 132'(m);
    end
    return acc > ((132'(lim_dist) * 132'(lim_dist)) << 32);
  endfunction

  function automatic out_item_t trace_ray(in_item_t it);
    logic [31:0] o [3];
    logic [15:0] dr [3];
    logic [16:0] mag;
    logic [63:0] q;
    logic [15:0] fr;
    logic [16:0] f;
    int ax;
    o[0] = it.origin_x; o[1] = it.origin_y; o[2] = it.origin_z;
    dr[0] = it.dir_x; dr[1] = it.dir_y; dr[2] = it.dir_z;
    if (it.operation == OpStart) begin
      for (int a = 0; a < 3; a++) begin
        mag = dr[a][15] ? 17'h10000 - 17'(dr[a]) : 17'(dr[a]);
        org[a] = o[a];
        cell_pos[a] = o[a][31:16];
        fr = o[a][15:0];
        sgn[a] = (mag == 0) ? SignZero : (dr[a][15] ? SignMinus : SignPlus);
        if (mag == 0) begin
          dlt[a] = DeltaSat;
          sdist[a] = SideSat;
        end else begin
          q = (64'd1 << 31) / 64'(mag);
          if (q > 64'(DeltaSat)) q = 64'(DeltaSat);
          f = dr[a][15] ? 17'(fr) : 17'h10000 - 17'(fr);
          dlt[a] = q[31:0];
          sdist[a] = 40'((64'(f) * q) >> 16);
        end
      end
      trace_on = 1'b1;
      prev_axis = AxisNone;
      nsteps = '0;
      return make_result(StatQuery, FaceNone, 1'b0);
    end
    if (!trace_on) return make_result(StatNoRay, FaceNone, 1'b1);
    if (it.occupied) begin
      trace_on = 1'b0;
      if (prev_axis == AxisNone) return make_result(StatHit, FaceNone, 1'b0);
      return make_result(StatHit,
        3'(2 * prev_axis + ((sgn[prev_axis] == SignPlus) ? 0 : 1)), 1'b0);
    end
    // pick axis with the smallest boundary distance, ties go to the later axis
    if (sdist[0] < sdist[1] && sdist[0] < sdist[2]) ax = 0;
    else if (sdist[1] < sdist[2]) ax = 1;
    else ax = 2;
    sdist[ax] = (41'(sdist[ax]) + 41'(dlt[ax]) > 41'(SideSat)) ? SideSat
              : sdist[ax] + 40'(dlt[ax]);
    if (sgn[ax] == SignPlus) cell_pos[ax] = cell_pos[ax] + 16'd1;
    else if (sgn[ax] == SignMinus) cell_pos[ax] = cell_pos[ax] - 16'd1;
    prev_axis = 2'(ax);
    nsteps = nsteps + 10'd1;
    if (past_range() || nsteps >= lim_steps) begin
      trace_on = 1'b0;
      return make_result(StatMiss, FaceNone, 1'b0);
    end
    return make_result(StatQuery, FaceNone, 1'b0);
  endfunction

  // Driver: present pending transactions at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_q.size() > 0 && (noidle_in || $urandom_range(99) >= 32)) begin
          in_valid <= 1'b1;
          in_data <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_out || (!noidle_out && $urandom_range(99) < 32);
    end
  end

  // Monitor: predict on accepted inputs, check accepted outputs
  always @(posedge clk) begin
    out_item_t w;
    in_fire = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'(out_data), 64'd0);
        end else begin
          w = expected_q.pop_front();
          if (out_data.voxel_x !== w.voxel_x) report("voxel_x", 64'(out_data.voxel_x), 64'(w.voxel_x));
          if (out_data.voxel_y !== w.voxel_y) report("voxel_y", 64'(out_data.voxel_y), 64'(w.voxel_y));
          if (out_data.voxel_z !== w.voxel_z) report("voxel_z", 64'(out_data.voxel_z), 64'(w.voxel_z));
          if (out_data.status !== w.status) report("status", 64'(out_data.status), 64'(w.status));
          if (out_data.face !== w.face) report("face", 64'(out_data.face), 64'(w.face));
          if (out_data.steps_taken !== w.steps_taken)
            report("steps_taken", 64'(out_data.steps_taken), 64'(w.steps_taken));
        end
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        expected_q.insert(expected_q.size(), trace_ray(in_data));
      end
    end
  end

  function automatic in_item_t start_item(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
    in_item_t it;
    it = '{operation: OpStart, origin_x: ox, origin_y: oy, origin_z: oz,
           dir_x: dx, dir_y: dy, dir_z: dz, occupied: 1'($urandom_range(1))};
    return it;
  endfunction

  function automatic in_item_t answer_item(bit occ);
    in_item_t it;
    it = '{operation: OpAnswer, origin_x: $urandom, origin_y: $urandom, origin_z: $urandom,
           dir_x: 16'($urandom), dir_y: 16'($urandom), dir_z: 16'($urandom), occupied: occ};
    return it;
  endfunction

  function automatic in_item_t random_start();
    logic [31:0] o [3];
    logic [15:0] d [3];
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(3))
        0: o[a] = $urandom;
        default: o[a] = 32'($signed($urandom_range(4000)) - 2000) << 8;
      endcase
      case ($urandom_range(5))
        0: d[a] = '0;
        1: d[a] = 16'($urandom_range(8) - 4);
        default: d[a] = 16'($urandom);
      endcase
    end
    return start_item(o[0], o[1], o[2], d[0], d[1], d[2]);
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgMaxDistance) lim_dist = val;
    else if (idx == CfgMaxSteps) lim_steps = val[9:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queue a ray as a start followed by mostly empty answers
  task automatic queue_ray(int len);
    enqueue(random_start());
    for (int k = 0; k < len; k++) enqueue(answer_item($urandom_range(29) == 0));
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0; out_stall = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    noidle_in = 0; noidle_out = 0; hold_out = 0;
    errors = 0;
    lim_dist = 16'd200; lim_steps = 10'd500; trace_on = 0; prev_axis = AxisNone; nsteps = '0;
    for (int a = 0; a < 3; a++) begin
      cell_pos[a] = '0; org[a] = '0; sgn[a] = SignZero; dlt[a] = '0; sdist[a] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: answers with no ray, extremes, hits on the x+, y- and z- faces, tie handling
    enqueue(answer_item(0));
    enqueue(answer_item(1));
    enqueue(start_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000,
                       16'h8000, 16'h7FFF, 16'h0000));
    enqueue(answer_item(1));
    enqueue(start_item(32'h0001_8000, 32'hFFFF_0000, 32'h0, 16'h7FFF, 16'h0, 16'h0));
    enqueue(answer_item(0));
    enqueue(answer_item(1));
    enqueue(start_item(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0));
    enqueue(answer_item(0));
    enqueue(answer_item(0));
    enqueue(start_item(32'h0, 32'h0, 32'h0, 16'h0, 16'hC000, 16'h0));
    enqueue(answer_item(0));
    enqueue(answer_item(1));
    enqueue(start_item(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000));
    enqueue(answer_item(0));
    enqueue(start_item(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h8001));
    enqueue(answer_item(0));
    enqueue(answer_item(1));
    enqueue(start_item(32'h0, 32'h0, 32'h0, 16'h0001, 16'hFFFF, 16'h2000));
    enqueue(answer_item(0));
    enqueue(answer_item(1));
    wait_drained();

    // Tight limits: tiny distance and step count, unknown index ignored
    write_reg(CfgMaxDistance, 16'd1);
    write_reg(CfgMaxSteps, 16'd1);
    write_reg(CfgUnused, 16'hFFFF);
    for (int r = 0; r < 20; r++) queue_ray($urandom_range(4));
    wait_drained();

    // Zero step limit acts like one; widest distance
    write_reg(CfgMaxSteps, 16'd0);
    write_reg(CfgMaxDistance, 16'hFFFF);
    for (int r = 0; r < 10; r++) queue_ray($urandom_range(3));
    wait_drained();

    write_reg(CfgMaxSteps, 16'h3FF);
    write_reg(CfgMaxDistance, 16'd12);
    sent = 0;
    // Long stretch without idling on either side
    noidle_in = 1; noidle_out = 1;
    for (int r = 0; r < 8; r++) queue_ray(10);
    wait_drained();
    noidle_in = 0; noidle_out = 0;

    // Receiver hold-off while the sender keeps offering
    fork
      begin
        hold_out = 1;
        repeat (600) @(posedge clk);
        hold_out = 0;
      end
    join_none
    for (int r = 0; r < 4; r++) queue_ray(6);
    wait_drained();

    write_reg(CfgMaxSteps, 16'd40);
    write_reg(CfgMaxDistance, 16'd30);
    while (sent < 560) begin
      if ($urandom_range(9) == 0) begin
        enqueue(answer_item(1'($urandom_range(1))));
        sent++;
      end else begin
        int len;
        len = $urandom_range(25);
        queue_ray(len);
        sent += len + 1;
      end
      if ($urandom_range(15) == 0) wait_drained();
      while (pending_q.size() > 20) @(posedge clk);
    end
    wait_drained();

    if (errors == 0) begin
      $display("[voxel_grid_ray_traversal_unit] OK");
    end else begin
      $display("[voxel_grid_ray_traversal_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[voxel_grid_ray_traversal_unit] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
